@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define UBT_ASSERT_SAME(label, trig, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (prop)) \
      else $error("bag table check failed");

// property that must hold in the cycle after its trigger
`define UBT_ASSERT_NEXT(label, trig, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error("bag table check failed");

`endif

@@ hw/rtl/ubt_pkg.sv @@
// types and codes of the unordered bag table
package ubt_pkg;

   // command codes
   localparam logic [2:0] CMD_ADD       = 3'd0;
   localparam logic [2:0] CMD_REMOVE    = 3'd1;
   localparam logic [2:0] CMD_COUNT     = 3'd2;
   localparam logic [2:0] CMD_RETRIEVE  = 3'd3;
   localparam logic [2:0] CMD_CLEAR     = 3'd4;
   localparam logic [2:0] CMD_SEGREGATE = 3'd5;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [6:0]  match_count;
      logic [15:0] taken_value;
      logic [6:0]  size_now;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_RM_READ,
      ST_RM_WRITE,
      ST_RT_READ0,
      ST_RT_READ1,
      ST_RT_WRITE,
      ST_SEG_W1,
      ST_SEG_W2,
      ST_SEG_READ,
      ST_SEG_W3,
      ST_SEG_W4,
      ST_DONE
   } state_type;

endpackage

@@ hw/rtl/ubt_ram.sv @@
// generic single write port, single read port ram with registered read
module ubt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/unordered_bag_table.sv @@
// Unordered bag table: a multiset of up to CAPACITY values held in one ram, slots 0 to
// size-1. One request is taken at a time; each gives exactly one response. Remove, count
// and segregate scan the held entries through the single ram read port, one entry per
// cycle; remove then moves the last entry on a hit and segregate does its two swaps. The
// ram needs no clearing after reset; the entry count alone tells which slots hold data. A
// new request is accepted while the previous response still waits on the output register.
module unordered_bag_table #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ubt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ubt_pkg::rsp_type rsp_data
);
   import ubt_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   state_type             state_ff, state_in;
   logic [2:0]            cmd_ff, cmd_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic                  vld_ff, vld_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         mc_ff, mc_in;
   logic                  found_ff, found_in;
   logic [IW-1:0]         first_ff, first_in;
   logic [IW-1:0]         mn_ff, mn_in;
   logic [IW-1:0]         mx_ff, mx_in;
   logic [VALUE_BITS-1:0] mnv_ff, mnv_in;
   logic [VALUE_BITS-1:0] mxv_ff, mxv_in;
   logic [VALUE_BITS-1:0] v0_ff, v0_in;
   logic [VALUE_BITS-1:0] taken_ff, taken_in;
   logic                  ok_ff, ok_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [IW-1:0]         rd_addr;
   logic [VALUE_BITS-1:0] rd_data;

   logic [CW-1:0]         count_dec;
   logic [IW-1:0]         last_idx;
   logic [IW-1:0]         mx_sel;

   // entry store
   ubt_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (CAPACITY),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // slot of the last entry and where the maximum sits after the first swap
   assign count_dec = count_ff - CW'(1);
   assign last_idx  = count_dec[IW-1:0];
   assign mx_sel    = (mx_ff == '0) ? mn_ff : mx_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      val_ff      <= val_in;
      ptr_ff      <= ptr_in;
      idx_ff      <= idx_in;
      mc_ff       <= mc_in;
      found_ff    <= found_in;
      first_ff    <= first_in;
      mn_ff       <= mn_in;
      mx_ff       <= mx_in;
      mnv_ff      <= mnv_in;
      mxv_ff      <= mxv_in;
      v0_ff       <= v0_in;
      taken_ff    <= taken_in;
      ok_ff       <= ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sequencer: next state, ram accesses and datapath updates
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      vld_in       = 1'b0;
      idx_in       = idx_ff;
      mc_in        = mc_ff;
      found_in     = found_ff;
      first_in     = first_ff;
      mn_in        = mn_ff;
      mx_in        = mx_ff;
      mnv_in       = mnv_ff;
      mxv_in       = mxv_ff;
      v0_in        = v0_ff;
      taken_in     = taken_ff;
      ok_in        = ok_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = val_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      case (state_ff)
         // take a request and dispatch on its command
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_data.cmd;
               val_in   = VALUE_BITS'(req_data.value);
               ptr_in   = '0;
               mc_in    = '0;
               found_in = 1'b0;
               taken_in = '0;
               ok_in    = 1'b0;
               case (req_data.cmd)
                  CMD_ADD: begin
                     state_in = ST_ADD;
                  end
                  CMD_REMOVE, CMD_COUNT, CMD_SEGREGATE: begin
                     state_in = ST_SCAN;
                  end
                  CMD_RETRIEVE: begin
                     state_in = (count_ff == '0) ? ST_DONE : ST_RT_READ0;
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                     ok_in    = 1'b1;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // append when there is room
         ST_ADD: begin
            if (count_ff < CW'(CAPACITY)) begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[IW-1:0];
               wr_data  = val_ff;
               count_in = count_ff + CW'(1);
               ok_in    = 1'b1;
            end
            state_in = ST_DONE;
         end

         // read one entry per cycle, compare the one read the cycle before
         ST_SCAN: begin
            if (ptr_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[IW-1:0];
               ptr_in  = ptr_ff + CW'(1);
               vld_in  = 1'b1;
               idx_in  = ptr_ff[IW-1:0];
            end
            if (vld_ff) begin
               if (rd_data == val_ff) begin
                  mc_in = mc_ff + CW'(1);
                  if (!found_ff) begin
                     found_in = 1'b1;
                     first_in = idx_ff;
                  end
               end
               if (idx_ff == '0) begin
                  v0_in  = rd_data;
                  mn_in  = '0;
                  mnv_in = rd_data;
                  mx_in  = '0;
                  mxv_in = rd_data;
               end else begin
                  if (rd_data < mnv_ff) begin
                     mn_in  = idx_ff;
                     mnv_in = rd_data;
                  end
                  if (rd_data > mxv_ff) begin
                     mx_in  = idx_ff;
                     mxv_in = rd_data;
                  end
               end
            end
            if ((ptr_ff == count_ff) && !vld_ff) begin
               case (cmd_ff)
                  CMD_COUNT: begin
                     ok_in    = (mc_ff != '0);
                     state_in = ST_DONE;
                  end
                  CMD_REMOVE: begin
                     state_in = found_ff ? ST_RM_READ : ST_DONE;
                  end
                  default: begin
                     ok_in    = (count_ff != '0);
                     state_in = (count_ff == '0) ? ST_DONE : ST_SEG_W1;
                  end
               endcase
            end
         end

         // remove: move the last entry into the hole
         ST_RM_READ: begin
            rd_en    = 1'b1;
            rd_addr  = last_idx;
            state_in = ST_RM_WRITE;
         end
         ST_RM_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = first_ff;
            wr_data  = rd_data;
            count_in = count_dec;
            ok_in    = 1'b1;
            state_in = ST_DONE;
         end

         // retrieve: take slot 0, move the last entry there
         ST_RT_READ0: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = ST_RT_READ1;
         end
         ST_RT_READ1: begin
            taken_in = rd_data;
            rd_en    = 1'b1;
            rd_addr  = last_idx;
            state_in = ST_RT_WRITE;
         end
         ST_RT_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = rd_data;
            count_in = count_dec;
            ok_in    = 1'b1;
            state_in = ST_DONE;
         end

         // segregate: minimum into slot 0
         ST_SEG_W1: begin
            wr_en    = 1'b1;
            wr_addr  = mn_ff;
            wr_data  = v0_ff;
            state_in = ST_SEG_W2;
         end
         ST_SEG_W2: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = mnv_ff;
            state_in = ST_SEG_READ;
         end

         // segregate: maximum into the last slot
         ST_SEG_READ: begin
            rd_en    = 1'b1;
            rd_addr  = last_idx;
            state_in = ST_SEG_W3;
         end
         ST_SEG_W3: begin
            wr_en    = 1'b1;
            wr_addr  = mx_sel;
            wr_data  = rd_data;
            state_in = ST_SEG_W4;
         end
         ST_SEG_W4: begin
            wr_en    = 1'b1;
            wr_addr  = last_idx;
            wr_data  = mxv_ff;
            state_in = ST_DONE;
         end

         // load the response once the output register is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.ok          = ok_ff;
               rsp_data_in.match_count = (cmd_ff == CMD_COUNT) ? 7'(mc_ff) : 7'd0;
               rsp_data_in.taken_value = 16'(taken_ff);
               rsp_data_in.size_now    = 7'(count_ff);
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hw/rtl/ubt_checker.sv @@
// port level checks of the unordered bag table and their bind
`include "assert_macros.svh"

module ubt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input ubt_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ubt_pkg::rsp_type rsp_data
);
   import ubt_pkg::*;

   logic       req_acc;
   logic       rsp_acc;
   logic [1:0] n_ff, n_in;
   logic [2:0] cmd0_ff, cmd0_in;
   logic [2:0] cmd1_ff, cmd1_in;
   logic [6:0] size_ff, size_in;
   logic       head_ok;
   logic       clear_head;
   logic       add_hit;
   logic       take_hit;
   logic       other_head;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;
   assign head_ok = rsp_valid && (n_ff != 2'd0);

   // which kind of response sits at the head
   assign clear_head = head_ok && (cmd0_ff == CMD_CLEAR);
   assign add_hit    = head_ok && (cmd0_ff == CMD_ADD) && rsp_data.ok;
   assign take_hit   = head_ok && (cmd0_ff inside {CMD_REMOVE, CMD_RETRIEVE}) && rsp_data.ok;
   assign other_head = head_ok && (cmd0_ff != CMD_COUNT);

   // commands of outstanding requests, oldest first, and the last reported size
   always_comb begin
      n_in    = n_ff;
      cmd0_in = cmd0_ff;
      cmd1_in = cmd1_ff;
      size_in = rsp_acc ? rsp_data.size_now : size_ff;
      case ({req_acc, rsp_acc})
         2'b10: begin
            n_in = n_ff + 2'd1;
            if (n_ff == 2'd0) begin
               cmd0_in = req_data.cmd;
            end else begin
               cmd1_in = req_data.cmd;
            end
         end
         2'b01: begin
            n_in    = n_ff - 2'd1;
            cmd0_in = cmd1_ff;
         end
         2'b11: begin
            if (n_ff == 2'd1) begin
               cmd0_in = req_data.cmd;
            end else begin
               cmd0_in = cmd1_ff;
               cmd1_in = req_data.cmd;
            end
         end
         default: begin
            n_in = n_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff    <= 2'd0;
         size_ff <= 7'd0;
      end else begin
         n_ff    <= n_in;
         size_ff <= size_in;
      end
      cmd0_ff <= cmd0_in;
      cmd1_ff <= cmd1_in;
   end

   // a stalled response holds
   `UBT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // clear always succeeds and empties the bag
   `UBT_ASSERT_SAME(a_clear_empties, clear_head, rsp_data.ok && (rsp_data.size_now == 7'd0))

   // a successful add grows the bag by one
   `UBT_ASSERT_SAME(a_add_grows, add_hit, rsp_data.size_now == (size_ff + 7'd1))

   // a successful remove or retrieve shrinks the bag by one
   `UBT_ASSERT_SAME(a_take_shrinks, take_hit, rsp_data.size_now == (size_ff - 7'd1))

   // only count reports matches
   `UBT_ASSERT_SAME(a_count_only, other_head, rsp_data.match_count == 7'd0)

endmodule

bind unordered_bag_table ubt_checker u_ubt_checker (.*);
